// ===== hw/rtl/ray_sphere_intersect_assert.svh =====
// Assertion macros for the ray and sphere intersection block.
// Used by ray_sphere_intersect; depends on nothing else.
`ifndef RAY_SPHERE_INTERSECT_ASSERT_SVH
`define RAY_SPHERE_INTERSECT_ASSERT_SVH

`ifndef SYNTHESIS
`define RSI_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define RSI_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RSI_ASSERT(label, clk, rst_n, prop)
`define RSI_ASSERT_NR(label, clk, prop)
`endif

`endif

// ===== hw/rtl/rsi_pkg.sv =====
// Shared constants and types for the ray and sphere intersection block.
// Used by rsi_div and ray_sphere_intersect.
package rsi_pkg;

  localparam int COORD_W = 32;
  localparam int DIST_W = 31;
  localparam int FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic pos;
    logic sat;
    logic miss;
  } rsi_root_flags_t;

endpackage

// ===== hw/rtl/rsi_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Carries a sideband vector alongside; depends on nothing else.
module rsi_sqrt #(
  parameter int SQW = 51,
  parameter int SBW = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  logic [2*SQW-1:0] in_d,
  input  logic [SBW-1:0]   in_sb,
  output logic             out_v,
  output logic [SQW-1:0]   out_e,
  output logic [SBW-1:0]   out_sb
);

  logic [SQW+1:0]   rem_r   [SQW];
  logic [SQW-1:0]   q_r     [SQW];
  logic [2*SQW-1:0] d_r     [SQW];
  logic [SBW-1:0]   sb_r    [SQW];
  logic [SQW-1:0]   v_r;

  logic [SQW+1:0]   rem_src [SQW];
  logic [SQW-1:0]   q_src   [SQW];
  logic [2*SQW-1:0] d_src   [SQW];
  logic [SBW-1:0]   sb_src  [SQW];
  logic [SQW+1:0]   rem_nxt [SQW];
  logic [SQW-1:0]   q_nxt   [SQW];

  always_comb begin
    logic [SQW+1:0] r2;
    logic [SQW+1:0] trial;
    logic           ge;
    for (int k = 0; k < SQW; k++) begin
      if (k == 0) begin
        rem_src[k] = '0;
        q_src[k] = '0;
        d_src[k] = in_d;
        sb_src[k] = in_sb;
      end else begin
        rem_src[k] = rem_r[k-1];
        q_src[k] = q_r[k-1];
        d_src[k] = d_r[k-1];
        sb_src[k] = sb_r[k-1];
      end
      r2 = {rem_src[k][SQW-1:0], d_src[k][2*SQW-1 -: 2]};
      trial = {q_src[k], 2'b01};
      ge = (r2 >= trial);
      rem_nxt[k] = ge ? (r2 - trial) : r2;
      q_nxt[k] = {q_src[k][SQW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQW; k++) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k] <= q_nxt[k];
        d_r[k] <= d_src[k] << 2;
        sb_r[k] <= sb_src[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[SQW-2:0], in_v};
    end
  end

  assign out_v = v_r[SQW-1];
  assign out_e = q_r[SQW-1];
  assign out_sb = sb_r[SQW-1];

endmodule

// ===== hw/rtl/rsi_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on rsi_pkg for the root flag struct.
module rsi_div
  import rsi_pkg::*;
#(
  parameter int AW = 48,
  parameter int RW = 79,
  parameter int QW = 31
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  logic [RW-1:0]   in_rem,
  input  logic [AW-1:0]   in_a,
  input  rsi_root_flags_t in_flags,
  output logic            out_v,
  output logic [QW-1:0]   out_q,
  output rsi_root_flags_t out_flags
);

  logic [RW-1:0]   rem_r   [QW];
  logic [QW-1:0]   q_r     [QW];
  logic [AW-1:0]   a_r     [QW];
  rsi_root_flags_t fl_r    [QW];
  logic [QW-1:0]   v_r;

  logic [RW-1:0]   rem_src [QW];
  logic [QW-1:0]   q_src   [QW];
  logic [AW-1:0]   a_src   [QW];
  rsi_root_flags_t fl_src  [QW];
  logic [RW-1:0]   rem_nxt [QW];
  logic [QW-1:0]   q_nxt   [QW];

  always_comb begin
    logic [RW-1:0] trial;
    logic          ge;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rem_src[k] = in_rem;
        q_src[k] = '0;
        a_src[k] = in_a;
        fl_src[k] = in_flags;
      end else begin
        rem_src[k] = rem_r[k-1];
        q_src[k] = q_r[k-1];
        a_src[k] = a_r[k-1];
        fl_src[k] = fl_r[k-1];
      end
      trial = RW'(a_src[k]) << (QW - 1 - k);
      ge = (rem_src[k] >= trial);
      rem_nxt[k] = ge ? (rem_src[k] - trial) : rem_src[k];
      q_nxt[k] = q_src[k] | (QW'(ge) << (QW - 1 - k));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k] <= q_nxt[k];
        a_r[k] <= a_src[k];
        fl_r[k] <= fl_src[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-2:0], in_v};
    end
  end

  assign out_v = v_r[QW-1];
  assign out_q = q_r[QW-1];
  assign out_flags = fl_r[QW-1];

endmodule

// ===== hw/rtl/ray_sphere_intersect.sv =====
// Path from request to result: seven arithmetic stages, one square root stage per root bit,
// one root stage, 31 divider stages and the output register. Throughput is one request per
// cycle, except while the pipeline holds.
// The whole pipeline holds while a finished result waits and the sink is not ready.
// Reset is synchronous and active low; it clears all valid bits and loads
// min_distance with round(0.007 * 2^FRAC_BITS).
module ray_sphere_intersect
  import rsi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_origin_x,
  input  logic signed [COORD_W-1:0] in_origin_y,
  input  logic signed [COORD_W-1:0] in_origin_z,
  input  logic signed [COORD_W-1:0] in_dir_x,
  input  logic signed [COORD_W-1:0] in_dir_y,
  input  logic signed [COORD_W-1:0] in_dir_z,
  input  logic signed [COORD_W-1:0] in_center_x,
  input  logic signed [COORD_W-1:0] in_center_y,
  input  logic signed [COORD_W-1:0] in_center_z,
  input  logic [DIST_W-1:0]         in_sphere_radius,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_hit,
  output logic [DIST_W-1:0]         out_distance,
  input  logic                      cfg_we,
  input  logic [DIST_W-1:0]         cfg_wdata
);

`include "ray_sphere_intersect_assert.svh"

  localparam int AW = 64 - FRAC_BITS;
  localparam int MW = 66 - FRAC_BITS;
  localparam int HW = (MW + 1) / 2;
  localparam int XW = 4 * HW;
  localparam int SQW = 67 - FRAC_BITS;
  localparam int DW2 = 2 * SQW;
  localparam int NW = SQW + 2;
  localparam int RW = AW + DIST_W;
  localparam int SBW = MW + 1 + AW + 1;
  localparam logic [DIST_W-1:0] MIN_DIST_RST = DIST_W'(((7 << FRAC_BITS) + 500) / 1000);
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  logic en;
  logic [DIST_W-1:0] min_dist_r;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r <= MIN_DIST_RST;
    end else if (cfg_we) begin
      min_dist_r <= cfg_wdata;
    end
  end

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r, s8_v_r;
  logic out_valid_r;
  logic sq_v;
  logic div_v1, div_v2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
      s8_v_r <= sq_v;
      out_valid_r <= div_v1;
    end
  end

  // Stage 1: origin minus center.
  logic signed [COORD_W:0]   s1_oc_r [3];
  logic signed [COORD_W-1:0] s1_d_r  [3];
  logic [DIST_W-1:0]         s1_rad_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_oc_r[0] <= $signed({in_origin_x[COORD_W-1], in_origin_x})
                  - $signed({in_center_x[COORD_W-1], in_center_x});
      s1_oc_r[1] <= $signed({in_origin_y[COORD_W-1], in_origin_y})
                  - $signed({in_center_y[COORD_W-1], in_center_y});
      s1_oc_r[2] <= $signed({in_origin_z[COORD_W-1], in_origin_z})
                  - $signed({in_center_z[COORD_W-1], in_center_z});
      s1_d_r[0] <= in_dir_x;
      s1_d_r[1] <= in_dir_y;
      s1_d_r[2] <= in_dir_z;
      s1_rad_r <= in_sphere_radius;
    end
  end

  // Stage 2: per-axis products.
  logic signed [63:0] s2_dd_r [3];
  logic signed [64:0] s2_hp_r [3];
  logic signed [65:0] s2_cp_r [3];
  logic [61:0]        s2_rr_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_dd_r[i] <= s1_d_r[i] * s1_d_r[i];
        s2_hp_r[i] <= s1_oc_r[i] * s1_d_r[i];
        s2_cp_r[i] <= s1_oc_r[i] * s1_oc_r[i];
      end
      s2_rr_r <= s1_rad_r * s1_rad_r;
    end
  end

  // Stage 3: quadratic coefficients.
  logic [63:0]        dd_sum;
  logic signed [MW:0] hterm [3];
  logic signed [MW:0] cterm [3];
  logic signed [MW:0] rterm;
  logic [61:0]        rr_sh;
  logic [AW-1:0]      s3_a_r;
  logic signed [MW:0] s3_h_r, s3_c_r;

  always_comb begin
    dd_sum = $unsigned(s2_dd_r[0]) + $unsigned(s2_dd_r[1]) + $unsigned(s2_dd_r[2]);
    for (int i = 0; i < 3; i++) begin
      hterm[i] = (MW+1)'(s2_hp_r[i] >>> FRAC_BITS);
      cterm[i] = (MW+1)'(s2_cp_r[i] >>> FRAC_BITS);
    end
    rr_sh = s2_rr_r >> FRAC_BITS;
    rterm = signed'((MW+1)'(rr_sh));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_a_r <= dd_sum[63:FRAC_BITS];
      s3_h_r <= hterm[0] + hterm[1] + hterm[2];
      s3_c_r <= cterm[0] + cterm[1] + cterm[2] - rterm;
    end
  end

  // Stage 4: magnitudes and signs.
  logic [MW-1:0]      s4_habs_r, s4_cabs_r;
  logic [AW-1:0]      s4_a_r;
  logic signed [MW:0] s4_h_r;
  logic               s4_cpos_r, s4_azero_r;
  logic signed [MW:0] hneg, cneg;

  assign hneg = -s3_h_r;
  assign cneg = -s3_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_habs_r <= s3_h_r[MW] ? hneg[MW-1:0] : s3_h_r[MW-1:0];
      s4_cabs_r <= s3_c_r[MW] ? cneg[MW-1:0] : s3_c_r[MW-1:0];
      s4_a_r <= s3_a_r;
      s4_h_r <= s3_h_r;
      s4_cpos_r <= !s3_c_r[MW] && (s3_c_r != '0);
      s4_azero_r <= (s3_a_r == '0);
    end
  end

  // Stage 5: half-width partial products of h*h and a*|c|.
  logic [2*HW-1:0] hx, ax, cx;
  logic [2*HW-1:0] s5_hhh_r, s5_hhl_r, s5_hll_r;
  logic [2*HW-1:0] s5_ahch_r, s5_ahcl_r, s5_alch_r, s5_alcl_r;
  logic [AW-1:0]      s5_a_r;
  logic signed [MW:0] s5_h_r;
  logic               s5_cpos_r, s5_azero_r;

  assign hx = (2*HW)'(s4_habs_r);
  assign ax = (2*HW)'(s4_a_r);
  assign cx = (2*HW)'(s4_cabs_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s5_hhh_r <= hx[2*HW-1:HW] * hx[2*HW-1:HW];
      s5_hhl_r <= hx[2*HW-1:HW] * hx[HW-1:0];
      s5_hll_r <= hx[HW-1:0] * hx[HW-1:0];
      s5_ahch_r <= ax[2*HW-1:HW] * cx[2*HW-1:HW];
      s5_ahcl_r <= ax[2*HW-1:HW] * cx[HW-1:0];
      s5_alch_r <= ax[HW-1:0] * cx[2*HW-1:HW];
      s5_alcl_r <= ax[HW-1:0] * cx[HW-1:0];
      s5_a_r <= s4_a_r;
      s5_h_r <= s4_h_r;
      s5_cpos_r <= s4_cpos_r;
      s5_azero_r <= s4_azero_r;
    end
  end

  // Stage 6: full products.
  logic [XW-1:0]      s6_h2_r, s6_ac_r;
  logic [AW-1:0]      s6_a_r;
  logic signed [MW:0] s6_h_r;
  logic               s6_cpos_r, s6_azero_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_h2_r <= (XW'(s5_hhh_r) << (2*HW)) + (XW'(s5_hhl_r) << (HW+1)) + XW'(s5_hll_r);
      s6_ac_r <= (XW'(s5_ahch_r) << (2*HW)) + (XW'(s5_ahcl_r) << HW)
               + (XW'(s5_alch_r) << HW) + XW'(s5_alcl_r);
      s6_a_r <= s5_a_r;
      s6_h_r <= s5_h_r;
      s6_cpos_r <= s5_cpos_r;
      s6_azero_r <= s5_azero_r;
    end
  end

  // Stage 7: discriminant and miss decision.
  logic [XW:0]        dsum, ddif;
  logic [DW2-1:0]     s7_disc_r;
  logic [AW-1:0]      s7_a_r;
  logic signed [MW:0] s7_h_r;
  logic               s7_miss_r;

  assign dsum = {1'b0, s6_h2_r} + {1'b0, s6_ac_r};
  assign ddif = {1'b0, s6_h2_r} - {1'b0, s6_ac_r};

  always_ff @(posedge clk) begin
    if (en) begin
      s7_disc_r <= s6_cpos_r ? DW2'(ddif) : DW2'(dsum);
      s7_miss_r <= s6_azero_r || (s6_cpos_r && ddif[XW]);
      s7_a_r <= s6_a_r;
      s7_h_r <= s6_h_r;
    end
  end

  // Square root of the discriminant.
  logic [SQW-1:0]     sq_e;
  logic [SBW-1:0]     sq_sb;
  logic signed [MW:0] sq_h;
  logic [AW-1:0]      sq_a;
  logic               sq_miss;

  rsi_sqrt #(
    .SQW(SQW),
    .SBW(SBW)
  ) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (s7_v_r),
    .in_d   (s7_disc_r),
    .in_sb  ({s7_h_r, s7_a_r, s7_miss_r}),
    .out_v  (sq_v),
    .out_e  (sq_e),
    .out_sb (sq_sb)
  );

  assign {sq_h, sq_a, sq_miss} = sq_sb;

  // Stage 8: root numerators and saturation checks.
  logic signed [NW-1:0] num1, num2, hx_n, ex_n;
  logic [RW-1:0]        n1, n2, a_lim;
  logic [RW-1:0]        s8_n1_r, s8_n2_r;
  logic [AW-1:0]        s8_a_r;
  rsi_root_flags_t      s8_f1_r, s8_f2_r;

  always_comb begin
    hx_n = NW'(sq_h);
    ex_n = signed'({2'b00, sq_e});
    num1 = -hx_n - ex_n;
    num2 = -hx_n + ex_n;
    n1 = RW'(num1[NW-2:0]) << FRAC_BITS;
    n2 = RW'(num2[NW-2:0]) << FRAC_BITS;
    a_lim = RW'(sq_a) << DIST_W;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_n1_r <= n1;
      s8_n2_r <= n2;
      s8_a_r <= sq_a;
      s8_f1_r.pos <= !num1[NW-1] && (num1 != '0);
      s8_f1_r.sat <= (n1 >= a_lim);
      s8_f1_r.miss <= sq_miss;
      s8_f2_r.pos <= !num2[NW-1] && (num2 != '0);
      s8_f2_r.sat <= (n2 >= a_lim);
      s8_f2_r.miss <= sq_miss;
    end
  end

  // Both roots divided in parallel lanes.
  logic [DIST_W-1:0] q1, q2;
  rsi_root_flags_t   f1, f2;

  rsi_div #(
    .AW(AW),
    .RW(RW),
    .QW(DIST_W)
  ) u_div_near (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (s8_v_r),
    .in_rem    (s8_n1_r),
    .in_a      (s8_a_r),
    .in_flags  (s8_f1_r),
    .out_v     (div_v1),
    .out_q     (q1),
    .out_flags (f1)
  );

  rsi_div #(
    .AW(AW),
    .RW(RW),
    .QW(DIST_W)
  ) u_div_far (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (s8_v_r),
    .in_rem    (s8_n2_r),
    .in_a      (s8_a_r),
    .in_flags  (s8_f2_r),
    .out_v     (div_v2),
    .out_q     (q2),
    .out_flags (f2)
  );

  // Output register: nearer accepted root wins.
  logic [DIST_W-1:0] t1, t2;
  logic              ok1, ok2;
  logic              out_hit_r;
  logic [DIST_W-1:0] out_dist_r;

  always_comb begin
    t1 = f1.sat ? DIST_MAX : q1;
    t2 = f2.sat ? DIST_MAX : q2;
    ok1 = !f1.miss && f1.pos && (t1 > min_dist_r);
    ok2 = !f2.miss && f2.pos && (t2 > min_dist_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r <= ok1 || ok2;
      out_dist_r <= ok1 ? t1 : (ok2 ? t2 : '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit = out_hit_r;
  assign out_distance = out_dist_r;

  `RSI_ASSERT(a_lanes_lockstep, clk, rst_n, div_v1 == div_v2)
  `RSI_ASSERT(a_miss_zero, clk, rst_n, (out_valid_r && !out_hit_r) |-> (out_dist_r == '0))
  `RSI_ASSERT(a_hit_beyond_min, clk, rst_n, (out_valid_r && out_hit_r) |-> (out_dist_r > min_dist_r))
  `RSI_ASSERT_NR(a_reset_clears, clk, !rst_n |=> !out_valid_r)

endmodule
